// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the set engine. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SOE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set engine check failed");

// Next-cycle implication, checked outside reset.
`define SOE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set engine check failed");

`endif

// ===== rtl/core/soe_pkg.sv =====
`timescale 1ns / 1ps

package soe_pkg;

  localparam int DEF_SET_DEPTH     = 32;
  localparam int DEF_ELEMENT_WIDTH = 32;
  localparam int MAX_RESULTS       = 32;
  localparam int K_W               = $clog2(MAX_RESULTS + 1);
  localparam int MAX_ELEM_W        = 64;
  localparam int CMD_W             = 3;
  localparam int IN_ELEM_W         = 32;
  localparam int OUT_VALUE_W       = 32;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR      = 3'd0,
    OP_LOAD_A     = 3'd1,
    OP_LOAD_B     = 3'd2,
    OP_INTERSECT  = 3'd3,
    OP_DIFFERENCE = 3'd4,
    OP_CONTAINS   = 3'd5,
    OP_EXACT      = 3'd6
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    op_t  op;
    logic prep;
    logic outer_step;
    logic inner_step;
    logic advance_i;
    logic set_start;
    logic hit_take;
    logic out_final;
    logic out_flag;
    logic ans_set;
    logic ans_val;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic size_ok;
    logic outer_done;
    logic inner_vld;
    logic match;
    logic pend_valid;
  } dp_sts_t;

endpackage

// ===== rtl/core/soe_channels.sv =====
`timescale 1ns / 1ps

interface soe_in_if;
  import soe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [IN_ELEM_W-1:0] element;
  logic                 strict;

  modport source (output valid, command, element, strict, input ready);
  modport sink   (input valid, command, element, strict, output ready);
endinterface

interface soe_out_if;
  import soe_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OUT_VALUE_W-1:0] value;
  logic                   has_value;
  logic                   answer;
  logic                   overflow;
  logic                   last;

  modport source (output valid, value, has_value, answer, overflow, last, input ready);
  modport sink   (input valid, value, has_value, answer, overflow, last, output ready);
endinterface

// ===== rtl/core/soe_datapath.sv =====
`timescale 1ns / 1ps

module soe_datapath #(
  parameter int SET_DEPTH     = soe_pkg::DEF_SET_DEPTH,
  parameter int ELEMENT_WIDTH = soe_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  soe_pkg::dp_cmd_t                   cmd,
  input  logic [soe_pkg::CMD_W-1:0]          in_command,
  input  logic [soe_pkg::IN_ELEM_W-1:0]      in_element,
  input  logic                               in_strict,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [soe_pkg::OUT_VALUE_W-1:0]    out_value,
  output logic                               out_has_value,
  output logic                               out_answer,
  output logic                               out_overflow,
  output logic                               out_last,
  output soe_pkg::dp_sts_t                   sts
);
  import soe_pkg::*;

  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SET_DEPTH);

  logic [ELEMENT_WIDTH-1:0] mem_a [SET_DEPTH];
  logic [ELEMENT_WIDTH-1:0] mem_b [SET_DEPTH];
  logic [ELEMENT_WIDTH-1:0] rd_a_r, rd_b_r, pend_r;

  logic [CNT_W-1:0] count_a_r, count_b_r;
  logic [CNT_W-1:0] i_r, j_r, jq_r, start_r, n_outer_r, probe_n_r;
  logic [K_W-1:0]   k_r;
  logic             inner_vld_r, outer_is_a_r, strict_r, ans_r, ovf_r, pend_valid_r;

  logic                   out_valid_r, out_has_value_r, out_answer_r, out_overflow_r;
  logic                   out_last_r;
  logic [OUT_VALUE_W-1:0] out_value_r;

  logic [MAX_ELEM_W-1:0]    elem_ext, pend_ext;
  logic [ELEMENT_WIDTH-1:0] elem_w, outer_rd, inner_rd;
  logic [CNT_W-1:0]         j_start, j_end, inner_addr;
  logic                     is_walk, prep_outer_is_a, re_outer, re_inner;
  logic                     re_a, re_b, load_full_a, load_full_b;
  logic [IDX_W-1:0]         addr_a, addr_b;
  logic                     out_free, out_load;

  assign elem_ext = MAX_ELEM_W'(in_element);
  assign elem_w   = elem_ext[ELEMENT_WIDTH-1:0];
  assign pend_ext = MAX_ELEM_W'(pend_r);

  assign is_walk  = (cmd.op == OP_INTERSECT) || (cmd.op == OP_DIFFERENCE);
  assign outer_rd = outer_is_a_r ? rd_a_r : rd_b_r;
  assign inner_rd = outer_is_a_r ? rd_b_r : rd_a_r;

  assign load_full_a = (count_a_r >= DEPTH_C);
  assign load_full_b = (count_b_r >= DEPTH_C);

  // Intersect walks the smaller set, difference the larger; A/B order on a tie.
  always_comb begin
    case (cmd.op)
      OP_INTERSECT:  prep_outer_is_a = !(count_b_r < count_a_r);
      OP_DIFFERENCE: prep_outer_is_a = (count_b_r < count_a_r);
      default:       prep_outer_is_a = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_CONTAINS: begin
        j_start = start_r;
        j_end   = probe_n_r;
      end
      OP_EXACT: begin
        j_start = i_r;
        j_end   = i_r + CNT_W'(1);
      end
      default: begin
        j_start = '0;
        j_end   = probe_n_r;
      end
    endcase
  end

  assign inner_addr = cmd.outer_step ? j_start : j_r;
  assign re_outer   = cmd.outer_step;
  assign re_inner   = cmd.outer_step || (cmd.inner_step && (j_r < j_end));
  assign re_a       = outer_is_a_r ? re_outer : re_inner;
  assign re_b       = outer_is_a_r ? re_inner : re_outer;
  assign addr_a     = outer_is_a_r ? i_r[IDX_W-1:0] : inner_addr[IDX_W-1:0];
  assign addr_b     = outer_is_a_r ? inner_addr[IDX_W-1:0] : i_r[IDX_W-1:0];

  assign out_free = !out_valid_r || out_ready;
  assign out_load = cmd.out_final || cmd.out_flag || (cmd.hit_take && pend_valid_r);

  always_comb begin
    sts.out_free   = out_free;
    sts.inner_vld  = inner_vld_r;
    sts.match      = (outer_rd == inner_rd);
    sts.pend_valid = pend_valid_r;
    sts.outer_done = (i_r >= n_outer_r) || (is_walk && (k_r == K_W'(MAX_RESULTS)));
    case (cmd.op)
      OP_CONTAINS: sts.size_ok = (!strict_r && (count_a_r == count_b_r)) ||
                                 (count_a_r > count_b_r);
      OP_EXACT:    sts.size_ok = (count_a_r == count_b_r);
      default:     sts.size_ok = 1'b1;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r    <= '0;
      count_b_r    <= '0;
      inner_vld_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (op_t'(in_command))
          OP_CLEAR: begin
            count_a_r <= '0;
            count_b_r <= '0;
          end
          OP_LOAD_A: begin
            if (!load_full_a) count_a_r <= count_a_r + CNT_W'(1);
          end
          OP_LOAD_B: begin
            if (!load_full_b) count_b_r <= count_b_r + CNT_W'(1);
          end
          default: ;
        endcase
      end
      if (cmd.outer_step) begin
        inner_vld_r <= (j_start < j_end);
      end else if (cmd.inner_step) begin
        inner_vld_r <= (j_r < j_end);
      end
      if (cmd.prep) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.hit_take) begin
        pend_valid_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Set stores with registered read data.
  always_ff @(posedge clk) begin
    if (cmd.accept && (op_t'(in_command) == OP_LOAD_A) && !load_full_a) begin
      mem_a[count_a_r[IDX_W-1:0]] <= elem_w;
    end
    if (re_a) rd_a_r <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (op_t'(in_command) == OP_LOAD_B) && !load_full_b) begin
      mem_b[count_b_r[IDX_W-1:0]] <= elem_w;
    end
    if (re_b) rd_b_r <= mem_b[addr_b];
  end

  // Walk indices, flags and pending result.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      strict_r <= in_strict;
      ans_r    <= 1'b0;
      ovf_r    <= ((op_t'(in_command) == OP_LOAD_A) && load_full_a) ||
                  ((op_t'(in_command) == OP_LOAD_B) && load_full_b);
    end
    if (cmd.ans_set) ans_r <= cmd.ans_val;
    if (cmd.prep) begin
      i_r          <= '0;
      start_r      <= '0;
      k_r          <= '0;
      outer_is_a_r <= prep_outer_is_a;
      n_outer_r    <= prep_outer_is_a ? count_a_r : count_b_r;
      probe_n_r    <= prep_outer_is_a ? count_b_r : count_a_r;
    end
    if (cmd.outer_step) begin
      jq_r <= j_start;
      j_r  <= (j_start < j_end) ? j_start + CNT_W'(1) : j_start;
    end else if (cmd.inner_step && (j_r < j_end)) begin
      jq_r <= j_r;
      j_r  <= j_r + CNT_W'(1);
    end
    if (cmd.advance_i) i_r <= i_r + CNT_W'(1);
    if (cmd.set_start) start_r <= jq_r;
    if (cmd.hit_take) begin
      pend_r <= outer_rd;
      k_r    <= k_r + K_W'(1);
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.hit_take && pend_valid_r) begin
      out_value_r     <= pend_ext[OUT_VALUE_W-1:0];
      out_has_value_r <= 1'b1;
      out_answer_r    <= 1'b0;
      out_overflow_r  <= 1'b0;
      out_last_r      <= 1'b0;
    end else if (cmd.out_final) begin
      out_value_r     <= pend_valid_r ? pend_ext[OUT_VALUE_W-1:0] : '0;
      out_has_value_r <= pend_valid_r;
      out_answer_r    <= 1'b0;
      out_overflow_r  <= 1'b0;
      out_last_r      <= 1'b1;
    end else if (cmd.out_flag) begin
      out_value_r     <= '0;
      out_has_value_r <= 1'b0;
      out_answer_r    <= ans_r;
      out_overflow_r  <= ovf_r;
      out_last_r      <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_has_value = out_has_value_r;
  assign out_answer    = out_answer_r;
  assign out_overflow  = out_overflow_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/core/soe_controller.sv =====
`timescale 1ns / 1ps

module soe_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [soe_pkg::CMD_W-1:0] in_command,
  input  soe_pkg::dp_sts_t          sts,
  output logic                      in_ready,
  output soe_pkg::dp_cmd_t          cmd
);
  import soe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_OUTER,
    S_INNER,
    S_HIT,
    S_FINAL,
    S_FLAG
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   ready_r;
  logic   is_walk, found;

  assign in_ready = ready_r;
  assign is_walk  = op_r inside {OP_INTERSECT, OP_DIFFERENCE};

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    found     = sts.inner_vld;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          op_nxt     = op_t'(in_command);
          if (op_t'(in_command) inside {OP_INTERSECT, OP_DIFFERENCE, OP_CONTAINS, OP_EXACT}) begin
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_FLAG;
          end
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (!sts.size_ok) begin
          cmd.ans_set = 1'b1;
          state_nxt   = S_FLAG;
        end else begin
          state_nxt = S_OUTER;
        end
      end
      S_OUTER: begin
        if (sts.outer_done) begin
          if (is_walk) begin
            state_nxt = S_FINAL;
          end else begin
            cmd.ans_set = 1'b1;
            cmd.ans_val = 1'b1;
            state_nxt   = S_FLAG;
          end
        end else begin
          cmd.outer_step = 1'b1;
          state_nxt      = S_INNER;
        end
      end
      S_INNER: begin
        if (sts.inner_vld && !sts.match) begin
          cmd.inner_step = 1'b1;
        end else if (is_walk) begin
          if (found == (op_r == OP_INTERSECT)) begin
            state_nxt = S_HIT;
          end else begin
            cmd.advance_i = 1'b1;
            state_nxt     = S_OUTER;
          end
        end else if (found) begin
          cmd.advance_i = 1'b1;
          cmd.set_start = (op_r == OP_CONTAINS);
          state_nxt     = S_OUTER;
        end else begin
          cmd.ans_set = 1'b1;
          state_nxt   = S_FLAG;
        end
      end
      S_HIT: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.hit_take  = 1'b1;
          cmd.advance_i = 1'b1;
          state_nxt     = S_OUTER;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.out_final = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FLAG: begin
        if (sts.out_free) begin
          cmd.out_flag = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
      op_r    <= OP_CLEAR;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== rtl/core/set_operation_engine_core.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Fields                                        | Transfer
// in_ch    | in  | command, element, strict                      | valid && ready
// out_ch   | out | value, has_value, answer, overflow, last      | valid && ready
//
// Clear, load and unused commands: accept, then the result enters the output reg once it is free.
// Intersect and difference walk Nw elements of one set and search the Np elements of the other;
// contains and exact match walk B and search A. The inner search makes one compare per cycle
// against the registered read port of each set store.
// Reset (rst_n low, synchronous) empties both sets and drops any result in flight.
// A stalled out_ch holds the block at its next result; in_ch is ready only between commands.

`include "assert_macros.svh"

module set_operation_engine_core #(
  parameter int SET_DEPTH     = soe_pkg::DEF_SET_DEPTH,
  parameter int ELEMENT_WIDTH = soe_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  soe_in_if.sink    in_ch,
  soe_out_if.source out_ch
);
  import soe_pkg::*;

  // Command and status between sequencer and datapath.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer: accept one command, then step the walk until its last result is queued.
  soe_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .sts        (dp_sts),
    .in_ready   (in_ch.ready),
    .cmd        (dp_cmd)
  );

  // Datapath: set stores, counts, walk indices, pending element and output register.
  soe_datapath #(
    .SET_DEPTH     (SET_DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .in_command    (in_ch.command),
    .in_element    (in_ch.element),
    .in_strict     (in_ch.strict),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_value     (out_ch.value),
    .out_has_value (out_ch.has_value),
    .out_answer    (out_ch.answer),
    .out_overflow  (out_ch.overflow),
    .out_last      (out_ch.last),
    .sts           (dp_sts)
  );

  // Every accepted command leaves in_ch.ready low in the cycle after its transfer.
  `SOE_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, !in_ch.ready)
  // Push a pending element only into a free output register.
  `SOE_ASSERT_SAME(a_push_has_room, dp_cmd.hit_take && dp_sts.pend_valid, dp_sts.out_free)
  // An element result never carries a flag.
  `SOE_ASSERT_SAME(a_element_no_flag, out_ch.valid && out_ch.has_value,
                   !out_ch.answer && !out_ch.overflow)

endmodule

// ===== test/set_operation_engine_core_tb.sv =====
`timescale 1ns / 1ps

module set_operation_engine_core_tb;
  import soe_pkg::*;

  localparam int SET_DEPTH       = DEF_SET_DEPTH;
  localparam int EW              = DEF_ELEMENT_WIDTH;
  localparam logic [IN_ELEM_W-1:0] ELEM_MASK =
    (EW >= IN_ELEM_W) ? '1 : ((IN_ELEM_W'(1) << EW) - 1'b1);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS    = 350;
  localparam int CALM_AFTER      = 300;   // no idling once this many items went in
  localparam int LONG_HOLD       = 300;   // receiver hold-off, in cycles
  localparam int SETTLE_CYCLES   = 50;
  // Longer than the widest walk, which may make no transfer on either side.
  localparam int WATCHDOG_CYCLES = 8000;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    logic                   has_value;
    logic                   answer;
    logic                   overflow;
    logic                   last;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [IN_ELEM_W-1:0] elem;
    logic                 strict;
    logic                 fixed;
    reply_t               fixed_reply;
  } stim_row_t;

  localparam reply_t R_DONE = '{value: '0, has_value: 1'b0, answer: 1'b0,
                                overflow: 1'b0, last: 1'b1};
  localparam reply_t R_TRUE = '{value: '0, has_value: 1'b0, answer: 1'b1,
                                overflow: 1'b0, last: 1'b1};

  logic clk;
  logic rst_n;

  soe_in_if  in_ch ();
  soe_out_if out_ch ();

  set_operation_engine_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of both sets.
  logic [IN_ELEM_W-1:0] shadow_a [SET_DEPTH];
  logic [IN_ELEM_W-1:0] shadow_b [SET_DEPTH];
  int                   shadow_cnt_a;
  int                   shadow_cnt_b;

  reply_t               owed_replies [$];
  stim_row_t            directed_rows [$];
  logic [IN_ELEM_W-1:0] seq_pool [6];

  int err_cnt;
  int items_sent;
  bit idle_on;
  bit long_hold_req;

  // Work out the replies of one command and advance the shadow sets.
  function automatic void set_engine_reply(input logic [CMD_W-1:0] cmd,
                                           input logic [IN_ELEM_W-1:0] elem,
                                           input logic strict,
                                           output reply_t replies [$]);
    reply_t               r;
    logic [IN_ELEM_W-1:0] v;
    bit                   want, walk_a, found, ok;
    int                   walk_n, probe_n, start, i, j;
    replies = {};
    r = R_DONE;
    case (cmd)
      OP_CLEAR: begin
        shadow_cnt_a = 0;
        shadow_cnt_b = 0;
        replies.push_back(r);
      end
      OP_LOAD_A: begin
        if (shadow_cnt_a >= SET_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          shadow_a[shadow_cnt_a] = elem & ELEM_MASK;
          shadow_cnt_a++;
        end
        replies.push_back(r);
      end
      OP_LOAD_B: begin
        if (shadow_cnt_b >= SET_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          shadow_b[shadow_cnt_b] = elem & ELEM_MASK;
          shadow_cnt_b++;
        end
        replies.push_back(r);
      end
      OP_INTERSECT, OP_DIFFERENCE: begin
        want = (cmd == OP_INTERSECT);
        // A counts as the smaller set on a tie; intersect walks it, difference the other.
        walk_a = ((shadow_cnt_b >= shadow_cnt_a) == want);
        walk_n = walk_a ? shadow_cnt_a : shadow_cnt_b;
        probe_n = walk_a ? shadow_cnt_b : shadow_cnt_a;
        for (i = 0; i < walk_n && replies.size() < MAX_RESULTS; i++) begin
          v = walk_a ? shadow_a[i] : shadow_b[i];
          found = 1'b0;
          for (j = 0; j < probe_n; j++) begin
            if ((walk_a ? shadow_b[j] : shadow_a[j]) == v) found = 1'b1;
          end
          if (found == want) begin
            replies.push_back('{value: v, has_value: 1'b1, answer: 1'b0,
                                overflow: 1'b0, last: 1'b0});
          end
        end
        if (replies.size() == 0) replies.push_back(R_DONE);
        else replies[replies.size()-1].last = 1'b1;
      end
      OP_CONTAINS: begin
        ok = (!strict && shadow_cnt_a == shadow_cnt_b) || (shadow_cnt_a > shadow_cnt_b);
        start = 0;
        // Each search resumes at the previous match, that position included.
        for (i = 0; i < shadow_cnt_b && ok; i++) begin
          found = 1'b0;
          for (j = start; j < shadow_cnt_a; j++) begin
            if (!found && shadow_a[j] == shadow_b[i]) begin
              start = j;
              found = 1'b1;
            end
          end
          ok = found;
        end
        r.answer = ok;
        replies.push_back(r);
      end
      OP_EXACT: begin
        ok = (shadow_cnt_a == shadow_cnt_b);
        for (i = 0; i < shadow_cnt_b && ok; i++) begin
          if (shadow_a[i] != shadow_b[i]) ok = 1'b0;
        end
        r.answer = ok;
        replies.push_back(r);
      end
      default: replies.push_back(r);
    endcase
  endfunction

  function automatic stim_row_t stim_row(input logic [CMD_W-1:0] cmd,
                                         input logic [IN_ELEM_W-1:0] elem,
                                         input logic strict, input logic fixed,
                                         input reply_t fixed_reply);
    stim_row_t s;
    s = '{cmd: cmd, elem: elem, strict: strict, fixed: fixed, fixed_reply: fixed_reply};
    return s;
  endfunction

  // Mostly draw from the per-sequence pool so sets overlap; sometimes a full-range value.
  function automatic logic [IN_ELEM_W-1:0] pick_element();
    if ($urandom_range(0, 3) != 0) return seq_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Offer one command, hold it until the transfer, then queue what it owes.
  task automatic transfer_cmd(input logic [CMD_W-1:0] cmd, input logic [IN_ELEM_W-1:0] elem,
                              input logic strict, input logic fixed,
                              input reply_t fixed_reply);
    reply_t predicted [$];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.element <= elem;
    in_ch.strict  <= strict;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    set_engine_reply(cmd, elem, strict, predicted);
    if (fixed) owed_replies.push_back(fixed_reply);
    else foreach (predicted[k]) owed_replies.push_back(predicted[k]);
    items_sent++;
    @(negedge clk);
  endtask

  // Pause the sender until every owed reply has come back.
  task automatic wait_all_replies();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (owed_replies.size() != 0);
  endtask

  task automatic report_field(input string name, input logic [OUT_VALUE_W-1:0] want,
                              input logic [OUT_VALUE_W-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each result transfer with the oldest owed reply.
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_replies.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none owed, expected nothing, actual %h/%b%b%b%b", $time,
                 out_ch.value, out_ch.has_value, out_ch.answer, out_ch.overflow, out_ch.last);
      end else begin
        want = owed_replies.pop_front();
        report_field("value", want.value, out_ch.value);
        report_field("has_value", OUT_VALUE_W'(want.has_value), OUT_VALUE_W'(out_ch.has_value));
        report_field("answer", OUT_VALUE_W'(want.answer), OUT_VALUE_W'(out_ch.answer));
        report_field("overflow", OUT_VALUE_W'(want.overflow), OUT_VALUE_W'(out_ch.overflow));
        report_field("last", OUT_VALUE_W'(want.last), OUT_VALUE_W'(out_ch.last));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on each request.
  initial begin : receiver
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Drop the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
    $display("set_operation_engine_core_tb: errors");
    $finish;
  end

  initial begin : main_flow
    logic [IN_ELEM_W-1:0] a_loaded [$];
    logic [IN_ELEM_W-1:0] b_vals [$];
    op_t                  query_ops [4];
    int                   seq, na, nb, nq, mode, b_mode, k;
    bit                   full_a, full_b;

    query_ops = '{OP_INTERSECT, OP_DIFFERENCE, OP_CONTAINS, OP_EXACT};
    err_cnt = 0;
    items_sent = 0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    shadow_cnt_a = 0;
    shadow_cnt_b = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = OP_CLEAR;
    in_ch.element = '0;
    in_ch.strict = 1'b0;

    // Empty sets, unused command, extremes, in-order search, tie rules.
    directed_rows.push_back(stim_row(OP_INTERSECT,  '0, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_DIFFERENCE, '0, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_CONTAINS,   '0, 1'b0, 1'b1, R_TRUE));
    directed_rows.push_back(stim_row(OP_CONTAINS,   '0, 1'b1, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_EXACT,      '0, 1'b0, 1'b1, R_TRUE));
    directed_rows.push_back(stim_row(CMD_UNUSED,    '1, 1'b1, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_LOAD_A,     '0, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_LOAD_A,     '1, 1'b1, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_LOAD_A,     32'h1234_5678, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_LOAD_B,     '1, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_LOAD_B,     '0, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_INTERSECT,  '0, 1'b0, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_DIFFERENCE, '0, 1'b0, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_CONTAINS,   '0, 1'b0, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_CONTAINS,   '0, 1'b1, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_EXACT,      '0, 1'b0, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_LOAD_B,     32'h1234_5678, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_CONTAINS,   '0, 1'b0, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_CONTAINS,   '0, 1'b1, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_INTERSECT,  '0, 1'b0, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(OP_DIFFERENCE, '0, 1'b0, 1'b0, R_DONE));
    directed_rows.push_back(stim_row(CMD_UNUSED,    32'h0F0F_F0F0, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_CLEAR,      '1, 1'b1, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_LOAD_B,     32'hA5A5_A5A5, 1'b0, 1'b1, R_DONE));
    directed_rows.push_back(stim_row(OP_CONTAINS,   '0, 1'b0, 1'b1, R_DONE));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      transfer_cmd(directed_rows[r].cmd, directed_rows[r].elem, directed_rows[r].strict,
                   directed_rows[r].fixed, directed_rows[r].fixed_reply);
    end
    wait_all_replies();

    // Random sequences: usually a clear, then load A, load B and a handful of queries.
    seq = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      if (seq == 2 || seq == 11) long_hold_req = 1'b1;
      if (seq == 6) wait_all_replies();
      foreach (seq_pool[p]) seq_pool[p] = ($urandom_range(0, 1) != 0) ? $urandom
                                                                      : $urandom_range(0, 15);
      if ($urandom_range(0, 4) != 0) transfer_cmd(OP_CLEAR, $urandom,
                                                  1'($urandom_range(0, 1)), 1'b0, R_DONE);
      mode = $urandom_range(0, 9);
      full_a = (mode == 0) || (mode == 1 && $urandom_range(0, 1) != 0);
      full_b = (mode == 0 && $urandom_range(0, 1) != 0) || (mode == 1 && !full_a);
      na = full_a ? SET_DEPTH + $urandom_range(1, 2) : $urandom_range(0, 6);
      a_loaded = {};
      for (k = 0; k < na; k++) begin
        a_loaded.push_back(pick_element());
        transfer_cmd(OP_LOAD_A, a_loaded[k], 1'($urandom_range(0, 1)), 1'b0, R_DONE);
      end

      b_mode = $urandom_range(0, 3);
      b_vals = {};
      case (b_mode)
        0: foreach (a_loaded[q]) if ($urandom_range(0, 2) != 0) b_vals.push_back(a_loaded[q]);
        1: b_vals = a_loaded;
        default: begin
          nb = full_b ? SET_DEPTH + $urandom_range(1, 2) : $urandom_range(0, 6);
          for (k = 0; k < nb; k++) b_vals.push_back(pick_element());
        end
      endcase
      foreach (b_vals[q]) transfer_cmd(OP_LOAD_B, b_vals[q], 1'($urandom_range(0, 1)),
                                       1'b0, R_DONE);

      nq = $urandom_range(2, 5);
      for (k = 0; k < nq; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any command code with random fields
          transfer_cmd(CMD_W'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)),
                       1'b0, R_DONE);
        end else begin
          transfer_cmd(query_ops[$urandom_range(0, 3)], $urandom, 1'($urandom_range(0, 1)),
                       1'b0, R_DONE);
        end
      end
      seq++;
    end

    wait_all_replies();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("set_operation_engine_core_tb: clean");
    end else begin
      $display("set_operation_engine_core_tb: errors");
    end
    $finish;
  end

endmodule
